### hdl/ptc_pkg.sv
`timescale 1ns / 1ps

package ptc_pkg;

  // calibration register file
  localparam int CAL_COUNT = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CAL_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CAL_SENS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CAL_OFF      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CAL_TCS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CAL_TCO      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CAL_TREF     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CAL_TEMPSENS = 3'd5;

  // temperature break points in hundredths of a degree
  localparam logic signed [20:0] TEMP_REF  = 21'sd2000;
  localparam logic signed [20:0] TEMP_HOT  = 21'sd4500;
  localparam logic signed [20:0] TEMP_COLD = -21'sd1500;

  // pressure saturation limits
  localparam logic signed [49:0] P_MAX = 50'sd2147483647;
  localparam logic signed [49:0] P_MIN = -50'sd2147483648;

  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } ptc_in_t;

  typedef struct packed {
    logic signed [18:0] temperature_centi;
    logic signed [31:0] pressure_centi;
  } ptc_out_t;

endpackage

### hdl/pressure_temperature_compensation.sv
// Throughput: one request per cycle while out_stall is low, through a
// nine-stage pipeline; the pressure product is split into two 24x22
// partial products a stage ahead. A stalled output holds only the stages
// behind it that are full.
// Reset (rst_n low, synchronous) empties the pipeline and clears the six
// calibration registers to zero.
`timescale 1ns / 1ps

module pressure_temperature_compensation (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ptc_pkg::ptc_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ptc_pkg::ptc_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ptc_pkg::CAL_W-1:0]         cfg_data
);
  import ptc_pkg::*;

  localparam int NST = 9;

  logic [CAL_W-1:0] cal_r [CAL_COUNT];

  logic [NST-1:0] v_r;
  logic [NST-1:0] v_nxt;
  logic [NST-1:0] adv;
  logic           in_acc;
  logic           out_acc;

  // stage 0
  logic signed [24:0] s0_dt_r, s0_dt_nxt;
  logic [23:0]        s0_d1_r;
  // stage 1
  logic signed [41:0] s1_pt_r, s1_po_r, s1_ps_r;
  logic signed [49:0] s1_dsq_r;
  logic [23:0]        s1_d1_r;
  // stage 2
  logic signed [41:0] s2_pt_bias, s2_po_bias, s2_ps_bias;
  logic signed [41:0] s2_pt_q, s2_po_q, s2_ps_q;
  logic signed [19:0] s2_temp_r, s2_temp_nxt;
  logic signed [41:0] s2_off_r, s2_off_nxt;
  logic signed [41:0] s2_sens_r, s2_sens_nxt;
  logic [17:0]        s2_t2_r;
  logic [23:0]        s2_d1_r;
  // stage 3
  logic signed [20:0] s3_temp_x;
  logic signed [20:0] s3_dcool, s3_dhot, s3_dcold;
  logic signed [41:0] s3_sqa_r, s3_sqb_r, s3_sqc_r;
  logic               s3_lt_ref_r, s3_gt_hot_r, s3_lt_cold_r;
  logic signed [19:0] s3_tout_x;
  logic signed [18:0] s3_tout_r;
  logic signed [41:0] s3_off_r, s3_sens_r;
  logic [23:0]        s3_d1_r;
  // stage 4
  logic signed [43:0] s4_sqa_x, s4_sqb_x, s4_sqc_x;
  logic signed [43:0] s4_off2, s4_sens2a, s4_sens2b;
  logic signed [43:0] s4_off_r, s4_off_nxt;
  logic signed [43:0] s4_sens_r, s4_sens_nxt;
  logic signed [18:0] s4_tout_r;
  logic [23:0]        s4_d1_r;
  // stage 5
  logic [45:0]        s5_pl_r;
  logic signed [46:0] s5_ph_r;
  logic signed [43:0] s5_off_r;
  logic signed [18:0] s5_tout_r;
  // stage 6
  logic signed [69:0] s6_prod_r, s6_prod_nxt;
  logic signed [43:0] s6_off_r;
  logic signed [18:0] s6_tout_r;
  // stage 7
  logic signed [69:0] s7_bias, s7_q;
  logic signed [49:0] s7_x_r, s7_x_nxt;
  logic signed [18:0] s7_tout_r;
  // stage 8 (output register)
  logic signed [49:0] s8_bias, s8_p;
  logic signed [31:0] s8_sat;
  ptc_out_t           out_data_r;

  // ---------------- handshake and valid chain ----------------
  always_comb begin
    adv[NST-1] = !v_r[NST-1] || !out_stall;
    for (int k = NST-2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
    v_nxt[0] = adv[0] ? in_valid : v_r[0];
    for (int k = 1; k < NST; k++) begin
      v_nxt[k] = adv[k] ? v_r[k-1] : v_r[k];
    end
  end

  assign in_stall  = !adv[0];
  assign in_acc    = in_valid && adv[0];
  assign out_valid = v_r[NST-1];
  assign out_acc   = v_r[NST-1] && !out_stall;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      for (int i = 0; i < CAL_COUNT; i++) begin
        cal_r[i] <= '0;
      end
    end else begin
      v_r <= v_nxt;
      // drop writes beyond the last register
      if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(CAL_COUNT))) begin
        cal_r[cfg_index] <= cfg_data;
      end
    end
  end

  // ---------------- datapath ----------------
  assign s0_dt_nxt = $signed({1'b0, in_data.raw_temperature})
                   - $signed({1'b0, cal_r[CAL_TREF], 8'h00});

  // truncate toward zero: bias negative values before the shift
  always_comb begin
    s2_pt_bias  = s1_pt_r[41] ? 42'sd8388607 : 42'sd0;
    s2_po_bias  = s1_po_r[41] ? 42'sd127 : 42'sd0;
    s2_ps_bias  = s1_ps_r[41] ? 42'sd255 : 42'sd0;
    s2_pt_q     = (s1_pt_r + s2_pt_bias) >>> 23;
    s2_po_q     = (s1_po_r + s2_po_bias) >>> 7;
    s2_ps_q     = (s1_ps_r + s2_ps_bias) >>> 8;
    s2_temp_nxt = TEMP_REF[19:0] + $signed(s2_pt_q[19:0]);
    s2_off_nxt  = $signed({10'b0, cal_r[CAL_OFF], 16'h0000}) + s2_po_q;
    s2_sens_nxt = $signed({11'b0, cal_r[CAL_SENS], 15'h0000}) + s2_ps_q;
  end

  // the dT square term applies only on the cool side
  always_comb begin
    s3_temp_x = {s2_temp_r[19], s2_temp_r};
    s3_dcool  = s3_temp_x - TEMP_REF;
    s3_dhot   = s3_temp_x - TEMP_HOT;
    s3_dcold  = s3_temp_x - TEMP_COLD;
    s3_tout_x = (s3_temp_x < TEMP_REF) ? s2_temp_r - $signed({2'b00, s2_t2_r})
                                       : s2_temp_r;
  end

  // second-order terms; all three tests use the first-order temperature
  always_comb begin
    s4_sqa_x  = {{2{s3_sqa_r[41]}}, s3_sqa_r};
    s4_sqb_x  = {{2{s3_sqb_r[41]}}, s3_sqb_r};
    s4_sqc_x  = {{2{s3_sqc_r[41]}}, s3_sqc_r};
    s4_off2   = s3_lt_ref_r ? (s4_sqa_x <<< 1) + s4_sqa_x : 44'sd0;
    priority if (s3_lt_ref_r) begin
      s4_sens2a = ((s4_sqa_x <<< 3) - s4_sqa_x) >>> 3;
    end else if (s3_gt_hot_r) begin
      s4_sens2a = -(s4_sqb_x >>> 3);
    end else begin
      s4_sens2a = 44'sd0;
    end
    s4_sens2b   = s3_lt_cold_r ? (s4_sqc_x <<< 1) : 44'sd0;
    s4_off_nxt  = {{2{s3_off_r[41]}}, s3_off_r} - s4_off2;
    s4_sens_nxt = {{2{s3_sens_r[41]}}, s3_sens_r} - s4_sens2a - s4_sens2b;
  end

  assign s6_prod_nxt = ({{23{s5_ph_r[46]}}, s5_ph_r} <<< 22) + $signed({24'b0, s5_pl_r});

  always_comb begin
    s7_bias  = s6_prod_r[69] ? 70'sd2097151 : 70'sd0;
    s7_q     = (s6_prod_r + s7_bias) >>> 21;
    s7_x_nxt = $signed(s7_q[49:0]) - {{6{s6_off_r[43]}}, s6_off_r};
  end

  always_comb begin
    s8_bias = s7_x_r[49] ? 50'sd32767 : 50'sd0;
    s8_p    = (s7_x_r + s8_bias) >>> 15;
    priority if (s8_p > P_MAX) begin
      s8_sat = P_MAX[31:0];
    end else if (s8_p < P_MIN) begin
      s8_sat = P_MIN[31:0];
    end else begin
      s8_sat = s8_p[31:0];
    end
  end

  // advance each stage when the one after it has room
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_dt_r <= s0_dt_nxt;
      s0_d1_r <= in_data.raw_pressure;
    end
    if (adv[1]) begin
      s1_pt_r  <= s0_dt_r * $signed({1'b0, cal_r[CAL_TEMPSENS]});
      s1_po_r  <= s0_dt_r * $signed({1'b0, cal_r[CAL_TCO]});
      s1_ps_r  <= s0_dt_r * $signed({1'b0, cal_r[CAL_TCS]});
      s1_dsq_r <= s0_dt_r * s0_dt_r;
      s1_d1_r  <= s0_d1_r;
    end
    if (adv[2]) begin
      s2_temp_r <= s2_temp_nxt;
      s2_off_r  <= s2_off_nxt;
      s2_sens_r <= s2_sens_nxt;
      s2_t2_r   <= s1_dsq_r[48:31];
      s2_d1_r   <= s1_d1_r;
    end
    if (adv[3]) begin
      s3_sqa_r     <= s3_dcool * s3_dcool;
      s3_sqb_r     <= s3_dhot * s3_dhot;
      s3_sqc_r     <= s3_dcold * s3_dcold;
      s3_lt_ref_r  <= s3_temp_x < TEMP_REF;
      s3_gt_hot_r  <= s3_temp_x > TEMP_HOT;
      s3_lt_cold_r <= s3_temp_x < TEMP_COLD;
      s3_tout_r    <= s3_tout_x[18:0];
      s3_off_r     <= s2_off_r;
      s3_sens_r    <= s2_sens_r;
      s3_d1_r      <= s2_d1_r;
    end
    if (adv[4]) begin
      s4_off_r  <= s4_off_nxt;
      s4_sens_r <= s4_sens_nxt;
      s4_tout_r <= s3_tout_r;
      s4_d1_r   <= s3_d1_r;
    end
    if (adv[5]) begin
      s5_pl_r   <= s4_d1_r * s4_sens_r[21:0];
      s5_ph_r   <= $signed({1'b0, s4_d1_r}) * $signed(s4_sens_r[43:22]);
      s5_off_r  <= s4_off_r;
      s5_tout_r <= s4_tout_r;
    end
    if (adv[6]) begin
      s6_prod_r <= s6_prod_nxt;
      s6_off_r  <= s5_off_r;
      s6_tout_r <= s5_tout_r;
    end
    if (adv[7]) begin
      s7_x_r    <= s7_x_nxt;
      s7_tout_r <= s6_tout_r;
    end
    if (adv[8]) begin
      out_data_r.temperature_centi <= s7_tout_r;
      out_data_r.pressure_centi    <= s8_sat;
    end
  end

  // ---------------- assertions ----------------
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> $countones(v_r) == $past($countones(v_r)) + $past(32'(in_acc))
                                - $past(32'(out_acc)))
    else $error("pipeline occupancy does not match accepted and delivered requests");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ((&v_r) && out_stall))
    else $error("input stalled while the pipeline has room");

  a_temp_bands: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[3] |-> (!(s3_gt_hot_r && s3_lt_ref_r) && (!s3_lt_cold_r || s3_lt_ref_r)))
    else $error("temperature correction bands overlap");

  a_cal_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && cfg_index == CAL_TREF) |=>
      cal_r[CAL_TREF] == $past(cfg_data))
    else $error("calibration write lost");

endmodule
